@@ hdl/mrfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfr_pkg
// Shared types and constants for the meter reply frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfr_pkg;

    // Frame marker and command bytes
    localparam logic [7:0] END_MARK = 8'h0D;
    localparam logic [7:0] CMD_A    = 8'hAA;
    localparam logic [7:0] CMD_B    = 8'hA5;

    // Inter-byte timer value after reset (2000 / 10 ticks)
    localparam logic [7:0] TIMEOUT_RESET = 8'(2000 / 10);

    // Byte positions inside a frame (0-based count)
    localparam logic [8:0] POS_ADDR    = 9'd0;
    localparam logic [8:0] POS_HDR_END = 9'd3;
    localparam logic [8:0] POS_INNER   = 9'd4;
    localparam logic [8:0] POS_CMD     = 9'd5;
    localparam logic [8:0] POS_TAG1    = 9'd6;
    localparam logic [8:0] POS_TAG2    = 9'd7;
    localparam logic [8:0] POS_LEN     = 9'd8;

    // Bytes outside the data field
    localparam logic [8:0] FRAME_OVERHEAD = 9'd11;

    // Event codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Reported status
    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_OK       = 3'd1,
        ST_ADDR_ERR = 3'd2,
        ST_CMD_ERR  = 3'd3,
        ST_TAG_ERR  = 3'd4,
        ST_LEN_ERR  = 3'd5,
        ST_TIMEOUT  = 3'd6
    } t_status;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_METER_ADDR = 3'd0,
        CFG_TAG_FIRST  = 3'd1,
        CFG_TAG_SECOND = 3'd2,
        CFG_EXP_LEN    = 3'd3,
        CFG_TIMEOUT    = 3'd4
    } t_cfg_reg;

endpackage

`default_nettype wire

@@ hdl/mrfr_if.sv @@
// ----------------------------------------------------------------------------
// mrfr_in_if / mrfr_out_if
// Valid/ready channels for received events and for status items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrfr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, opcode, rx_byte, input ready);
    modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface mrfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [8:0] frame_length;
    logic [7:0] data_length;

    modport source (output valid, status, frame_length, data_length, input ready);
    modport sink   (input valid, status, frame_length, data_length, output ready);
endinterface

`default_nettype wire

@@ hdl/meter_reply_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// meter_reply_frame_receiver_top
// Parses meter reply frames byte by byte and reports a status per event.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries events: opcode 0 is a received byte in rx_byte, opcode 1 is
//   a timer tick. Every accepted event yields exactly one item on o_out
//   (status, frame_length, data_length); status is busy except on frame
//   completion (ok or a check error) or on an inter-byte timeout.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes the
//   meter address, tag bytes, expected length and timeout; write it only
//   while no event is in flight. Indexes above 4 are dropped.
//   An accepted event passes the input register, then the parse logic feeding
//   the result register, which drives o_out.valid. Throughput is one event per
//   cycle while o_out takes items, set by the update of the frame state.
//   If o_out stalls, the result register holds and the input register still
//   takes one more event; i_in.ready drops only when both are full.
//   Reset clears the frame state, loads the timer with 200 ticks and sets
//   the configuration to its defaults; no item is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_reply_frame_receiver_top
    import mrfr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data,
    mrfr_in_if.sink    i_in,
    mrfr_out_if.source o_out
);

    // Configuration
    logic [7:0] r_meter_address, r_tag_first, r_tag_second, r_expected_length;
    logic [7:0] r_timeout_ticks;

    // Input register
    logic       r_in_valid;
    logic       r_in_opcode;
    logic [7:0] r_in_byte;

    // Frame state
    logic [8:0] r_byte_count,   n_byte_count;
    logic [7:0] r_running_sum,  n_running_sum;
    logic [7:0] r_length_field, n_length_field;
    logic       r_sum_matched,  n_sum_matched;
    logic [7:0] r_inner_address, n_inner_address;
    logic [7:0] r_command_byte,  n_command_byte;
    logic [7:0] r_tag_byte_one,  n_tag_byte_one;
    logic [7:0] r_tag_byte_two,  n_tag_byte_two;
    logic [7:0] r_idle_timer,    n_idle_timer;
    logic       r_timeout_reported, n_timeout_reported;

    // Result register
    logic       r_out_valid;
    t_status    r_out_status, n_out_status;
    logic [8:0] r_out_flen,   n_out_flen;
    logic [7:0] r_out_dlen;

    logic       advance;
    logic       out_free;
    t_status    frame_st;
    logic [8:0] sum_end;
    logic       byte_ok;
    logic       frame_done;

    // Handshake: the parse stage moves when the result register is free
    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || out_free;

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.frame_length = r_out_flen;
    assign o_out.data_length  = r_out_dlen;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_address   <= '0;
            r_tag_first       <= '0;
            r_tag_second      <= '0;
            r_expected_length <= '0;
            r_timeout_ticks   <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_METER_ADDR: r_meter_address   <= i_cfg_data;
                CFG_TAG_FIRST:  r_tag_first       <= i_cfg_data;
                CFG_TAG_SECOND: r_tag_second      <= i_cfg_data;
                CFG_EXP_LEN:    r_expected_length <= i_cfg_data;
                CFG_TIMEOUT:    r_timeout_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_opcode <= i_in.opcode;
            r_in_byte   <= i_in.rx_byte;
        end
    end

    // Completion checks, first failure wins
    always_comb begin
        if (r_inner_address != r_meter_address) begin
            frame_st = ST_ADDR_ERR;
        end else if (r_command_byte != CMD_A && r_command_byte != CMD_B) begin
            frame_st = ST_CMD_ERR;
        end else if (r_tag_byte_one != r_tag_first || r_tag_byte_two != r_tag_second) begin
            frame_st = ST_TAG_ERR;
        end else if (r_length_field != r_expected_length) begin
            frame_st = ST_LEN_ERR;
        end else begin
            frame_st = ST_OK;
        end
    end

    // Last position covered by the checksum
    assign sum_end = {1'b0, r_length_field} + POS_LEN;

    // Parse one event
    always_comb begin
        n_byte_count       = r_byte_count;
        n_running_sum      = r_running_sum;
        n_length_field     = r_length_field;
        n_sum_matched      = r_sum_matched;
        n_inner_address    = r_inner_address;
        n_command_byte     = r_command_byte;
        n_tag_byte_one     = r_tag_byte_one;
        n_tag_byte_two     = r_tag_byte_two;
        n_idle_timer       = r_idle_timer;
        n_timeout_reported = r_timeout_reported;
        n_out_status       = ST_BUSY;
        n_out_flen         = r_byte_count;
        byte_ok            = 1'b1;
        frame_done         = 1'b0;

        if (r_in_opcode == OP_TICK) begin
            if (r_idle_timer != 8'd0) begin
                n_idle_timer = r_idle_timer - 8'd1;
            end
            if (n_idle_timer == 8'd0 && !r_timeout_reported) begin
                n_timeout_reported = 1'b1;
                n_out_status       = ST_TIMEOUT;
            end
        end else begin
            n_idle_timer       = r_timeout_ticks;
            n_timeout_reported = 1'b0;

            if (r_byte_count == POS_ADDR) begin
                byte_ok = (r_in_byte == r_meter_address);
            end else if (r_byte_count == POS_HDR_END) begin
                byte_ok = (r_in_byte == END_MARK);
            end else if (r_byte_count == POS_INNER) begin
                n_running_sum   = r_in_byte;
                n_inner_address = r_in_byte;
            end else if (r_byte_count > POS_INNER && r_byte_count <= POS_LEN) begin
                n_running_sum = r_running_sum + r_in_byte;
                if (r_byte_count == POS_CMD) begin
                    n_command_byte = r_in_byte;
                end else if (r_byte_count == POS_TAG1) begin
                    n_tag_byte_one = r_in_byte;
                end else if (r_byte_count == POS_TAG2) begin
                    n_tag_byte_two = r_in_byte;
                end else begin
                    n_length_field = r_in_byte;
                end
            end else if (r_byte_count > POS_LEN) begin
                if (r_byte_count <= sum_end) begin
                    n_running_sum = r_running_sum + r_in_byte;
                end else if (r_byte_count == sum_end + 9'd1) begin
                    n_sum_matched = (r_in_byte == r_running_sum);
                end else begin
                    byte_ok    = (r_in_byte == END_MARK) && r_sum_matched;
                    frame_done = byte_ok;
                end
            end

            if (!byte_ok) begin
                n_byte_count = '0;
                n_out_flen   = '0;
            end else if (frame_done) begin
                n_out_flen   = r_byte_count + 9'd1;
                n_out_status = frame_st;
                n_byte_count = '0;
            end else begin
                n_byte_count = r_byte_count + 9'd1;
                n_out_flen   = r_byte_count + 9'd1;
            end
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count       <= '0;
            r_running_sum      <= '0;
            r_length_field     <= '0;
            r_sum_matched      <= 1'b0;
            r_inner_address    <= '0;
            r_command_byte     <= '0;
            r_tag_byte_one     <= '0;
            r_tag_byte_two     <= '0;
            r_idle_timer       <= TIMEOUT_RESET;
            r_timeout_reported <= 1'b0;
        end else if (advance) begin
            r_byte_count       <= n_byte_count;
            r_running_sum      <= n_running_sum;
            r_length_field     <= n_length_field;
            r_sum_matched      <= n_sum_matched;
            r_inner_address    <= n_inner_address;
            r_command_byte     <= n_command_byte;
            r_tag_byte_one     <= n_tag_byte_one;
            r_tag_byte_two     <= n_tag_byte_two;
            r_idle_timer       <= n_idle_timer;
            r_timeout_reported <= n_timeout_reported;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= n_out_status;
            r_out_flen   <= n_out_flen;
            r_out_dlen   <= n_length_field;
        end
    end

    // A good frame always reports its full size
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK)
            |-> (r_out_flen == {1'b0, r_out_dlen} + FRAME_OVERHEAD))
        else $error("ok status with wrong frame length");

    // The count never runs past the end byte of the current frame
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= {1'b0, r_length_field} + FRAME_OVERHEAD - 9'd1)
        else $error("byte count beyond frame end");

    // A shown timeout is marked as reported
    a_timeout_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_TIMEOUT) |-> r_timeout_reported)
        else $error("timeout shown but not marked");

    // Taking the result frees the path for the pending event
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out.ready) |=> r_out_valid)
        else $error("pending event did not reach result register");

endmodule

`default_nettype wire

@@ tb/meter_reply_frame_receiver_checker.sv @@
// ----------------------------------------------------------------------------
// meter_reply_frame_receiver_checker
// Watches the event and status channels and the configuration port of the
// meter reply frame receiver. It runs its own model of the frame parser on
// every accepted event and compares each status item, field by field, with
// the oldest prediction. It hands the failure count and run statistics to
// the testbench top.
// ----------------------------------------------------------------------------
module meter_reply_frame_receiver_checker
    import mrfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    mrfr_in_if         i_in,
    mrfr_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_ok_frames,
    output int         o_rejected,
    output int         o_timeouts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        t_status    status;
        logic [8:0] frame_length;
        logic [7:0] data_length;
    } t_status_item;

    // Mirror of the configuration registers
    logic [7:0] cfg_addr, cfg_tag1, cfg_tag2, cfg_len, cfg_tmo;

    // Parser state
    logic [8:0] byte_pos;
    logic [7:0] csum;
    logic [7:0] len_field;
    logic       sum_ok;
    logic [7:0] inner_addr, cmd_byte, tag1_seen, tag2_seen;
    logic [7:0] idle_count;
    logic       timeout_flagged;

    t_status_item predicted_status[$];
    int           reports;

    // Checks of a complete frame, first failure wins
    function automatic t_status completion_status();
        if (inner_addr != cfg_addr) return ST_ADDR_ERR;
        if (cmd_byte != CMD_A && cmd_byte != CMD_B) return ST_CMD_ERR;
        if (tag1_seen != cfg_tag1 || tag2_seen != cfg_tag2) return ST_TAG_ERR;
        if (len_field != cfg_len) return ST_LEN_ERR;
        return ST_OK;
    endfunction

    // Advance the parser by one event and return the status item it causes
    function automatic t_status_item parse_event(logic op, logic [7:0] b);
        t_status_item r;
        logic [8:0]   idx;
        logic [8:0]   len9;
        logic         ok;
        logic         done;
        r.status = ST_BUSY;
        if (op == OP_TICK) begin
            if (idle_count != 8'd0) idle_count = idle_count - 8'd1;
            if (idle_count == 8'd0 && !timeout_flagged) begin
                timeout_flagged = 1'b1;
                r.status = ST_TIMEOUT;
            end
            r.frame_length = byte_pos;
        end else begin
            idx  = byte_pos;
            len9 = {1'b0, len_field};
            ok   = 1'b1;
            done = 1'b0;
            idle_count      = cfg_tmo;
            timeout_flagged = 1'b0;
            if (idx == POS_ADDR) begin
                ok = (b == cfg_addr);
            end else if (idx == POS_HDR_END) begin
                ok = (b == END_MARK);
            end else if (idx >= POS_INNER && idx <= POS_LEN) begin
                if (idx == POS_INNER) begin
                    csum = b;
                    inner_addr = b;
                end else begin
                    csum = csum + b;
                    case (idx)
                        POS_CMD:  cmd_byte = b;
                        POS_TAG1: tag1_seen = b;
                        POS_TAG2: tag2_seen = b;
                        default:  len_field = b;
                    endcase
                end
            end else if (idx > POS_LEN) begin
                // data bytes, then the checksum byte, then the end mark
                if (idx <= len9 + POS_LEN) begin
                    csum = csum + b;
                end else if (idx == len9 + POS_LEN + 9'd1) begin
                    sum_ok = (b == csum);
                end else begin
                    ok   = (b == END_MARK) && sum_ok;
                    done = ok;
                end
            end
            if (!ok) begin
                byte_pos = '0;
                r.frame_length = '0;
            end else if (done) begin
                r.frame_length = idx + 9'd1;
                r.status = completion_status();
                byte_pos = '0;
            end else begin
                byte_pos = idx + 9'd1;
                r.frame_length = byte_pos;
            end
        end
        r.data_length = len_field;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        o_fail_count++;
        if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        reports++;
    endtask

    // Watch configuration writes, status items and events
    always @(posedge i_clk) begin : watch
        t_status_item want;
        if (!i_rst_n) begin
            cfg_addr = '0;
            cfg_tag1 = '0;
            cfg_tag2 = '0;
            cfg_len  = '0;
            cfg_tmo  = TIMEOUT_RESET;
            byte_pos = '0;
            csum = '0;
            len_field = '0;
            sum_ok = 1'b0;
            inner_addr = '0;
            cmd_byte = '0;
            tag1_seen = '0;
            tag2_seen = '0;
            idle_count = TIMEOUT_RESET;
            timeout_flagged = 1'b0;
            predicted_status.delete();
            reports = 0;
            o_fail_count = 0;
            o_results = 0;
            o_ok_frames = 0;
            o_rejected = 0;
            o_timeouts = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_METER_ADDR: cfg_addr = i_cfg_data;
                    CFG_TAG_FIRST:  cfg_tag1 = i_cfg_data;
                    CFG_TAG_SECOND: cfg_tag2 = i_cfg_data;
                    CFG_EXP_LEN:    cfg_len  = i_cfg_data;
                    CFG_TIMEOUT:    cfg_tmo  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (predicted_status.size() == 0) begin
                    o_fail_count++;
                    if (reports < MAX_REPORTS)
                        $display("%0t: unexpected status item: status %0d length %0d data %0d",
                                 $time, i_out.status, i_out.frame_length, i_out.data_length);
                    reports++;
                end else begin
                    want = predicted_status.pop_front();
                    if (i_out.status != want.status)
                        report_mismatch("status", want.status, i_out.status);
                    if (i_out.frame_length != want.frame_length)
                        report_mismatch("frame_length", want.frame_length, i_out.frame_length);
                    if (i_out.data_length != want.data_length)
                        report_mismatch("data_length", want.data_length, i_out.data_length);
                    case (want.status)
                        ST_OK:      o_ok_frames++;
                        ST_TIMEOUT: o_timeouts++;
                        ST_BUSY:    ;
                        default:    o_rejected++;
                    endcase
                end
            end
            if (i_in.valid && i_in.ready)
                predicted_status.push_back(parse_event(i_in.opcode, i_in.rx_byte));
        end
        o_pending = predicted_status.size();
    end

endmodule

@@ tb/meter_reply_frame_receiver_top_tb.sv @@
// ----------------------------------------------------------------------------
// meter_reply_frame_receiver_top_tb
// Drives received bytes and timer ticks into the frame receiver: a few
// directed frames, then random well-formed and broken frames under changing
// configurations, with random gaps on both channels and long receiver
// stalls. The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module meter_reply_frame_receiver_top_tb
    import mrfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int LONG_HOLD    = 100;
    localparam int DRAIN_CYCLES = 8;

    typedef enum {
        FR_CLEAN,
        FR_BAD_ADDR,
        FR_BAD_HDR,
        FR_BAD_SUM,
        FR_BAD_END,
        FR_END_IS_ADDR,
        FR_CUT
    } t_frame_fault;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    mrfr_in_if  in_ch();
    mrfr_out_if out_ch();

    int fail_count, pending, results_seen, ok_frames, rejected, timeouts;

    // Stimulus bookkeeping and the values last written to the registers
    int         items_sent;
    int         config_sets;
    int         cycle_count;
    bit         src_burst;
    bit         stray_ticks;
    bit         sink_burst;
    logic [7:0] cur_addr, cur_tag1, cur_tag2, cur_len, cur_tmo;

    meter_reply_frame_receiver_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    meter_reply_frame_receiver_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_ok_frames  (ok_frames),
        .o_rejected   (rejected),
        .o_timeouts   (timeouts)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // Mostly the expected value, sometimes anything
    function automatic logic [7:0] mostly(logic [7:0] good);
        return ($urandom_range(0, 99) < 85) ? good : rand_byte();
    endfunction

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_A;
        if (r < 90) return CMD_B;
        return rand_byte();
    endfunction

    // Gap length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic send_event(input logic op, input logic [7:0] b);
        int gap;
        in_ch.opcode  <= op;
        in_ch.rx_byte <= b;
        in_ch.valid   <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        gap = src_burst ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_event(OP_TICK, rand_byte());
    endtask

    // Lower valid and wait until every status item has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_METER_ADDR: cur_addr = v;
            CFG_TAG_FIRST:  cur_tag1 = v;
            CFG_TAG_SECOND: cur_tag2 = v;
            CFG_EXP_LEN:    cur_len  = v;
            CFG_TIMEOUT:    cur_tmo  = v;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] addr, t1, t2, len, tmo);
        settle();
        write_reg(CFG_METER_ADDR, addr);
        write_reg(CFG_TAG_FIRST, t1);
        write_reg(CFG_TAG_SECOND, t2);
        write_reg(CFG_EXP_LEN, len);
        write_reg(CFG_TIMEOUT, tmo);
        config_sets++;
    endtask

    // Build one reply frame and send it, or the part of it that the fault keeps
    task automatic send_frame(input logic [7:0] inner, cmd, tag1, tag2, dlen,
                              input t_frame_fault fault);
        logic [7:0] frame_q[$];
        logic [7:0] b;
        logic [7:0] csum;
        int         last;
        frame_q.push_back(fault == FR_BAD_ADDR ? cur_addr ^ nonzero_byte() : cur_addr);
        frame_q.push_back(rand_byte());
        frame_q.push_back(rand_byte());
        frame_q.push_back(fault == FR_BAD_HDR ? END_MARK ^ nonzero_byte() : END_MARK);
        frame_q.push_back(inner);
        frame_q.push_back(cmd);
        frame_q.push_back(tag1);
        frame_q.push_back(tag2);
        frame_q.push_back(dlen);
        csum = inner + cmd + tag1 + tag2 + dlen;
        for (int i = 0; i < int'(dlen); i++) begin
            b = rand_byte();
            csum = csum + b;
            frame_q.push_back(b);
        end
        frame_q.push_back(fault == FR_BAD_SUM ? csum ^ nonzero_byte() : csum);
        case (fault)
            FR_BAD_END:     frame_q.push_back(END_MARK ^ nonzero_byte());
            FR_END_IS_ADDR: frame_q.push_back(cur_addr);
            default:        frame_q.push_back(END_MARK);
        endcase
        last = frame_q.size() - 1;
        if (fault == FR_BAD_ADDR) last = int'(POS_ADDR);
        else if (fault == FR_BAD_HDR) last = int'(POS_HDR_END);
        else if (fault == FR_CUT) last = $urandom_range(1, frame_q.size() - 2);
        for (int i = 0; i <= last; i++) begin
            // ticks in the middle of a frame must not restart the count
            if (stray_ticks && $urandom_range(0, 99) < 6) send_ticks($urandom_range(1, 2));
            send_event(OP_BYTE, frame_q[i]);
        end
    endtask

    task automatic random_frame();
        logic [7:0]   dlen;
        t_frame_fault fault;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 3) dlen = rand_byte();
        else if (r < 78) dlen = cur_len;
        else dlen = 8'($urandom_range(0, 12));
        r = $urandom_range(0, 99);
        if (r < 78) fault = FR_CLEAN;
        else if (r < 82) fault = FR_BAD_ADDR;
        else if (r < 86) fault = FR_BAD_HDR;
        else if (r < 90) fault = FR_BAD_SUM;
        else if (r < 94) fault = FR_BAD_END;
        else if (r < 96) fault = FR_END_IS_ADDR;
        else fault = FR_CUT;
        src_burst = ($urandom_range(0, 99) < 20);
        send_frame(mostly(cur_addr), pick_cmd(), mostly(cur_tag1), mostly(cur_tag2),
                   dlen, fault);
    endtask

    // Enough ticks to run the timer out when it is short
    task automatic tick_burst();
        if (cur_tmo <= 8'd40) send_ticks($urandom_range(1, int'(cur_tmo) + 3));
        else send_ticks($urandom_range(1, 6));
    endtask

    // Result side: random ready runs and gaps, plus two long hold-offs
    initial begin : result_sink
        int run;
        int holds_done;
        out_ch.ready = 1'b0;
        holds_done = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (holds_done < 2 && results_seen >= (holds_done + 1) * 500) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end else begin
                sink_burst = ($urandom_range(0, 99) < 15);
                out_ch.ready <= 1'b1;
                run = sink_burst ? $urandom_range(20, 60) : $urandom_range(1, 8);
                repeat (run) @(negedge i_clk);
                run = idle_len();
                if (run > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (run) @(negedge i_clk);
                end
            end
        end
    end

    // Event side: reset, directed frames, random phases, verdict
    initial begin : event_source
        int n;
        int r;
        in_ch.valid   = 1'b0;
        in_ch.opcode  = OP_BYTE;
        in_ch.rx_byte = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_METER_ADDR;
        i_cfg_data    = 8'h00;
        i_rst_n       = 1'b0;
        cur_addr = 8'h00;
        cur_tag1 = 8'h00;
        cur_tag2 = 8'h00;
        cur_len  = 8'h00;
        cur_tmo  = TIMEOUT_RESET;
        items_sent  = 0;
        config_sets = 1;
        src_burst   = 1'b0;
        stray_ticks = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset configuration
        send_event(OP_BYTE, 8'hFF);                                 // wrong address byte
        send_frame(8'h00, CMD_A, 8'h00, 8'h00, 8'h00, FR_BAD_HDR);  // wrong header end
        // bad end byte equal to the address must not open a new frame
        send_frame(8'h00, CMD_B, 8'h00, 8'h00, 8'h00, FR_END_IS_ADDR);
        send_frame(8'h00, CMD_A, 8'h00, 8'h00, 8'h00, FR_CLEAN);
        send_event(OP_TICK, 8'hFF);

        // Run the reset timer out, then keep ticking
        stray_ticks = 1'b1;
        send_ticks(int'(TIMEOUT_RESET) + 1);

        // Extreme settings
        set_config(8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF);
        repeat (4) random_frame();
        send_ticks(3);
        set_config(8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01);
        for (int k = int'(CFG_TIMEOUT) + 1; k < 8; k++) write_reg(3'(k), rand_byte());
        send_frame(cur_addr, CMD_A, cur_tag1, cur_tag2, 8'hFF, FR_CLEAN);
        send_ticks(3);
        set_config(rand_byte(), rand_byte(), rand_byte(), 8'($urandom_range(0, 6)), 8'h00);
        repeat (3) begin
            random_frame();
            send_ticks($urandom_range(1, 3));
        end

        // Random phases
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            set_config(r < 10 ? 8'h00 : (r < 20 ? 8'hFF : rand_byte()),
                       rand_byte(), rand_byte(), 8'($urandom_range(0, 12)),
                       r < 10 ? 8'h00 : (r < 65 ? 8'($urandom_range(1, 8)) :
                       (r < 90 ? 8'($urandom_range(9, 40)) : 8'($urandom_range(41, 255)))));
            n = $urandom_range(6, 14);
            repeat (n) begin
                random_frame();
                if ($urandom_range(0, 99) < 18) tick_burst();
                if ($urandom_range(0, 99) < 6)
                    repeat ($urandom_range(1, 3)) send_event(OP_BYTE, rand_byte());
                if (items_sent >= ITEM_TARGET) break;
            end
        end

        // Drain and verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d events under %0d register settings; %0d status items checked.",
                 items_sent, config_sets, results_seen);
        $display("Frames accepted %0d, frames failing a check %0d, timeouts %0d.",
                 ok_frames, rejected, timeouts);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ meter_reply_frame_receiver_top.f @@
hdl/mrfr_pkg.sv
hdl/mrfr_if.sv
hdl/meter_reply_frame_receiver_top.sv
tb/meter_reply_frame_receiver_checker.sv
tb/meter_reply_frame_receiver_top_tb.sv
